[design/ile_pkg.sv]
// Package for the image LSB text embedder: register codes, field widths,
// configuration and result structs, and the low-bit mask function.
// It has no dependencies and is used by every other file of the block except ile_ram.
package ile_pkg;

    localparam int TEXT_DEPTH_DEF = 4096;
    localparam int MAX_DIM_DEF    = 1024;

    localparam int BPP_W      = 4;
    localparam int STEP_W     = 11;
    localparam int DIM_W      = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int BYTE_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_PIXEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_STEP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd3;

    localparam logic [BPP_W-1:0] BPP_MAX = 4'd8;

    typedef struct packed {
        logic [BPP_W-1:0]  bits_per_pixel;
        logic [STEP_W-1:0] grid_step;
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] marked_pixel;
        logic              was_marked;
        logic [BYTE_W-1:0] hidden_value;
    } result_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [STEP_W-1:0] row_phase;
        logic [STEP_W-1:0] col_phase;
    } phase_stat_t;

    function automatic logic [BYTE_W-1:0] low_mask(input logic [BPP_W-1:0] b);
        logic [BYTE_W-1:0] m;
        if (b >= BPP_MAX) begin
            m = '1;
        end else begin
            m = (BYTE_W'(1) << b[2:0]) - BYTE_W'(1);
        end
        return m;
    endfunction

endpackage

[design/ile_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Reads return the old contents on a same-address write. No dependencies.
module ile_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[design/ile_cfg.sv]
// Configuration registers of the embedder, written through a plain write port.
// Depends on ile_pkg for the register codes and the cfg_t struct.
module ile_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [ile_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ile_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ile_pkg::cfg_t                    cfg
);

    ile_pkg::cfg_t cfg_reg;
    ile_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                ile_pkg::REG_BITS_PER_PIXEL:
                    cfg_next.bits_per_pixel = cfg_data[ile_pkg::BPP_W-1:0];
                ile_pkg::REG_GRID_STEP:
                    cfg_next.grid_step = cfg_data[ile_pkg::STEP_W-1:0];
                ile_pkg::REG_IMAGE_WIDTH:
                    cfg_next.image_width = cfg_data[ile_pkg::DIM_W-1:0];
                ile_pkg::REG_IMAGE_HEIGHT:
                    cfg_next.image_height = cfg_data[ile_pkg::DIM_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bits_per_pixel <= ile_pkg::BPP_W'(1);
            cfg_reg.grid_step      <= ile_pkg::STEP_W'(1);
            cfg_reg.image_width    <= ile_pkg::DIM_W'(1);
            cfg_reg.image_height   <= ile_pkg::DIM_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/ile_phase_div.sv]
// Bit-serial remainder unit: after a grid step write it recomputes the row
// and column phases (count + 1) mod step, one dividend bit per cycle.
// Depends on ile_pkg for the phase_stat_t struct and the step width.
module ile_phase_div #(
    parameter int DW = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ile_pkg::STEP_W-1:0]  divisor,
    input  logic [DW-1:0]               row_num,
    input  logic [DW-1:0]               col_num,
    output ile_pkg::phase_stat_t        stat
);

    localparam int CNTW = $clog2(DW);
    localparam int SW   = ile_pkg::STEP_W;

    function automatic logic [SW-1:0] rem_step(
        input logic [SW-1:0] rem,
        input logic          dbit,
        input logic [SW-1:0] d
    );
        logic [SW:0] r;
        r = {rem, dbit};
        if (r >= {1'b0, d})
        begin
            r = r - {1'b0, d};
        end
        return r[SW-1:0];
    endfunction

    logic            busy_reg;
    logic            busy_next;
    logic            done_reg;
    logic            done_next;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;
    logic [SW-1:0]   row_rem_reg;
    logic [SW-1:0]   row_rem_next;
    logic [SW-1:0]   col_rem_reg;
    logic [SW-1:0]   col_rem_next;

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        row_rem_next = row_rem_reg;
        col_rem_next = col_rem_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = CNTW'(DW - 1);
            row_rem_next = '0;
            col_rem_next = '0;
        end
        else if (busy_reg)
        begin
            row_rem_next = rem_step(row_rem_reg, row_num[cnt_reg], divisor);
            col_rem_next = rem_step(col_rem_reg, col_num[cnt_reg], divisor);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNTW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_rem_reg <= row_rem_next;
        col_rem_reg <= col_rem_next;
    end

    assign stat.busy      = busy_reg;
    assign stat.done      = done_reg;
    assign stat.row_phase = row_rem_reg;
    assign stat.col_phase = col_rem_reg;

endmodule

[design/ile_embed.sv]
// Embedding datapath: text store, text read pointer, raster and grid phase
// counters, and the per-pixel mark logic that feeds the result buffer.
// Depends on ile_pkg and instantiates ile_ram for the text store.
module ile_embed #(
    parameter int TEXT_DEPTH = ile_pkg::TEXT_DEPTH_DEF,
    parameter int MAX_DIM    = ile_pkg::MAX_DIM_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_accept,
    input  logic                                mode,
    input  logic [ile_pkg::BYTE_W-1:0]          text_byte,
    input  logic [ile_pkg::BYTE_W-1:0]          pixel,
    input  ile_pkg::cfg_t                       cfg,
    input  ile_pkg::phase_stat_t                phase,
    output logic [$clog2(MAX_DIM):0]            row_num,
    output logic [$clog2(MAX_DIM):0]            col_num,
    output logic                                res_push,
    output ile_pkg::result_t                    res_data
);

    localparam int RW   = $clog2(MAX_DIM);
    localparam int DW   = RW + 1;
    localparam int AW   = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int CW   = $clog2(TEXT_DEPTH + 1);
    localparam int SW   = ile_pkg::STEP_W;
    localparam int BW   = ile_pkg::BYTE_W;
    localparam int PW   = ile_pkg::BPP_W;
    localparam int CMPW = (DW > SW) ? DW : SW;
    localparam logic [CMPW-1:0] MAX_DIM_X    = CMPW'(MAX_DIM);
    localparam logic [CW-1:0]   TEXT_DEPTH_X = CW'(TEXT_DEPTH);

    function automatic logic [SW-1:0] ph_inc(
        input logic [SW-1:0] ph,
        input logic [SW-1:0] d
    );
        logic [SW:0] s;
        s = {1'b0, ph} + (SW+1)'(1);
        if (s == {1'b0, d})
        begin
            return '0;
        end
        return s[SW-1:0];
    endfunction

    function automatic logic [CMPW-1:0] clamp_dim(input logic [CMPW-1:0] v);
        logic [CMPW-1:0] c;
        c = v;
        if (v == '0)
        begin
            c = CMPW'(1);
        end
        else if (v > MAX_DIM_X)
        begin
            c = MAX_DIM_X;
        end
        return c;
    endfunction

    logic [CW-1:0] tc_reg;
    logic [CW-1:0] tc_next;
    logic [CW-1:0] ri_reg;
    logic [CW-1:0] ri_next;
    logic [2:0]    off_reg;
    logic [2:0]    off_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [RW-1:0] col_reg;
    logic [RW-1:0] col_next;
    logic [SW-1:0] row_ph_reg;
    logic [SW-1:0] row_ph_next;
    logic [SW-1:0] col_ph_reg;
    logic [SW-1:0] col_ph_next;
    logic [BW-1:0] cur_reg;
    logic [BW-1:0] cur_next;
    logic [BW-1:0] first_reg;
    logic [BW-1:0] first_next;
    logic          byp_valid_reg;
    logic          byp_valid_next;
    logic [BW-1:0] byp_data_reg;

    logic          pix_acc;
    logic          load_acc;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [AW-1:0] ram_rd_addr;
    logic [BW-1:0] ram_rd_data;
    logic [CW:0]   ri_p1;
    logic [CW:0]   ri_next_p1;

    logic [PW-1:0]   b;
    logic [BW-1:0]   mask;
    logic [SW-1:0]   d;
    logic            step_ok;
    logic [CMPW-1:0] row_p1_x;
    logic [CMPW-1:0] col_p1_x;
    logic [CMPW-1:0] w_cl;
    logic [CMPW-1:0] h_cl;
    logic            key;
    logic            grid_hit;
    logic            marked;
    logic            text_avail;
    logic [BW-1:0]   text_val;
    logic [PW-1:0]   off_sum;
    logic            take_text;
    logic [BW-1:0]   hidden;
    logic [BW-1:0]   pix_sum;
    logic [BW-1:0]   nxt_byte;
    logic            col_end;
    logic            row_end;
    logic [SW-1:0]   ph_first;

    assign pix_acc  = item_accept && mode;
    assign load_acc = item_accept && !mode;

    assign row_num = {1'b0, row_reg} + DW'(1);
    assign col_num = {1'b0, col_reg} + DW'(1);

    assign b        = (cfg.bits_per_pixel > ile_pkg::BPP_MAX) ? ile_pkg::BPP_MAX
                                                              : cfg.bits_per_pixel;
    assign mask     = ile_pkg::low_mask(b);
    assign d        = cfg.grid_step;
    assign step_ok  = (d != '0);
    assign row_p1_x = CMPW'(row_num);
    assign col_p1_x = CMPW'(col_num);
    assign w_cl     = clamp_dim(CMPW'(cfg.image_width));
    assign h_cl     = clamp_dim(CMPW'(cfg.image_height));

    assign key      = step_ok && (row_p1_x == CMPW'(d)) && (col_p1_x == CMPW'(d));
    assign grid_hit = step_ok && (row_ph_reg == '0) && (col_ph_reg == '0);
    assign marked   = key || grid_hit;

    assign text_avail = (b != '0) && (ri_reg < tc_reg);
    assign text_val   = (cur_reg >> off_reg) & mask;
    assign off_sum    = {1'b0, off_reg} + b;
    assign take_text  = pix_acc && !key && grid_hit && text_avail;

    always_comb
    begin
        if (key)
        begin
            hidden = {{(BW-PW){1'b0}}, b} & mask;
        end
        else if (grid_hit && text_avail)
        begin
            hidden = text_val;
        end
        else
        begin
            hidden = '0;
        end
    end

    assign pix_sum = pixel + hidden;

    assign res_push              = pix_acc;
    assign res_data.marked_pixel = marked ? ((pixel & ~mask) | (pix_sum & mask)) : pixel;
    assign res_data.was_marked   = marked;
    assign res_data.hidden_value = hidden;

    assign nxt_byte = byp_valid_reg ? byp_data_reg : ram_rd_data;
    assign col_end  = (col_p1_x >= w_cl);
    assign row_end  = (row_p1_x >= h_cl);
    assign ph_first = (d == SW'(1)) ? '0 : SW'(1);
    assign ri_p1    = {1'b0, ri_reg} + (CW+1)'(1);

    always_comb
    begin
        tc_next        = tc_reg;
        ri_next        = ri_reg;
        off_next       = off_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        row_ph_next    = row_ph_reg;
        col_ph_next    = col_ph_reg;
        cur_next       = cur_reg;
        first_next     = first_reg;
        byp_valid_next = 1'b0;
        ram_wr_en      = 1'b0;

        if (phase.done)
        begin
            row_ph_next = phase.row_phase;
            col_ph_next = phase.col_phase;
        end

        if (pix_acc)
        begin
            if (take_text)
            begin
                off_next = off_sum[2:0];
                if (off_sum > PW'(7))
                begin
                    ri_next  = ri_p1[CW-1:0];
                    cur_next = nxt_byte;
                end
            end
            if (col_end)
            begin
                col_next    = '0;
                col_ph_next = ph_first;
                if (row_end)
                begin
                    row_next    = '0;
                    row_ph_next = ph_first;
                    ri_next     = '0;
                    off_next    = '0;
                    cur_next    = first_reg;
                end
                else
                begin
                    row_next    = row_num[RW-1:0];
                    row_ph_next = ph_inc(row_ph_reg, d);
                end
            end
            else
            begin
                col_next    = col_num[RW-1:0];
                col_ph_next = ph_inc(col_ph_reg, d);
            end
        end

        if (load_acc && (tc_reg < TEXT_DEPTH_X))
        begin
            ram_wr_en = 1'b1;
            tc_next   = tc_reg + CW'(1);
            if (tc_reg == '0)
            begin
                first_next = text_byte;
            end
            if (tc_reg == ri_reg)
            begin
                cur_next = text_byte;
            end
            if ({1'b0, tc_reg} == ri_p1)
            begin
                byp_valid_next = 1'b1;
            end
        end
    end

    assign ri_next_p1  = {1'b0, ri_next} + (CW+1)'(1);
    assign ram_rd_addr = ri_next_p1[AW-1:0];
    assign ram_wr_addr = tc_reg[AW-1:0];

    ile_ram #(
        .WIDTH (BW),
        .DEPTH (TEXT_DEPTH)
    ) u_text_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (text_byte),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg        <= '0;
            ri_reg        <= '0;
            off_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            row_ph_reg    <= '0;
            col_ph_reg    <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            tc_reg        <= tc_next;
            ri_reg        <= ri_next;
            off_reg       <= off_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            row_ph_reg    <= row_ph_next;
            col_ph_reg    <= col_ph_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        first_reg    <= first_next;
        byp_data_reg <= text_byte;
    end

endmodule

[design/ile_out_buf.sv]
// Result output register with a one-beat skid stage, so that the input side
// sees a registered stall. Depends on ile_pkg for the result_t struct.
module ile_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ile_pkg::result_t  push_data,
    input  logic              out_stall,
    output logic              out_valid,
    output ile_pkg::result_t  out_data,
    output logic              full
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    ile_pkg::result_t out_data_reg;
    ile_pkg::result_t out_data_next;
    ile_pkg::result_t skid_data_reg;
    ile_pkg::result_t skid_data_next;
    logic             pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign full      = skid_valid_reg;

endmodule

[design/image_lsb_text_embedder.sv]
// Top level of the image LSB text embedder: configuration, phase recompute,
// embedding datapath and result buffer. Depends on ile_pkg and all ile_ modules.
//
//   Channel  Handshake               Beat contents
//   input    in_valid / in_stall     mode, text_byte, pixel
//   output   out_valid / out_stall   marked_pixel, was_marked, hidden_value
//   config   cfg_write               cfg_index, cfg_data
//
// One input beat is taken every cycle while in_stall is low; a pixel's result
// is registered into the output register, or into the skid stage while the
// output register holds a stalled beat; a text load gives no result.
// A grid_step write starts a bit-serial remainder pass that holds in_stall high.
// in_stall is also high while the skid stage holds a beat. Reset empties the
// text store and clears all counters; the store itself needs no clearing pass.
module image_lsb_text_embedder #(
    parameter int TEXT_DEPTH = ile_pkg::TEXT_DEPTH_DEF,
    parameter int MAX_DIM    = ile_pkg::MAX_DIM_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [ile_pkg::BYTE_W-1:0]        text_byte,
    input  logic [ile_pkg::BYTE_W-1:0]        pixel,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ile_pkg::BYTE_W-1:0]        marked_pixel,
    output logic                              was_marked,
    output logic [ile_pkg::BYTE_W-1:0]        hidden_value,
    input  logic                              cfg_write,
    input  logic [ile_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ile_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DW = $clog2(MAX_DIM) + 1;

    ile_pkg::cfg_t        cfg;
    ile_pkg::phase_stat_t phase;
    ile_pkg::result_t     res_data;
    ile_pkg::result_t     out_data;
    logic [DW-1:0]        row_num;
    logic [DW-1:0]        col_num;
    logic                 res_push;
    logic                 buf_full;
    logic                 step_write;
    logic                 item_accept;

    assign step_write  = cfg_write && (cfg_index == ile_pkg::REG_GRID_STEP);
    assign in_stall    = buf_full || phase.busy || phase.done;
    assign item_accept = in_valid && !in_stall;

    ile_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ile_phase_div #(
        .DW (DW)
    ) u_phase_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (step_write),
        .divisor (cfg.grid_step),
        .row_num (row_num),
        .col_num (col_num),
        .stat    (phase)
    );

    ile_embed #(
        .TEXT_DEPTH (TEXT_DEPTH),
        .MAX_DIM    (MAX_DIM)
    ) u_embed (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (item_accept),
        .mode        (mode),
        .text_byte   (text_byte),
        .pixel       (pixel),
        .cfg         (cfg),
        .phase       (phase),
        .row_num     (row_num),
        .col_num     (col_num),
        .res_push    (res_push),
        .res_data    (res_data)
    );

    ile_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .full      (buf_full)
    );

    assign marked_pixel = out_data.marked_pixel;
    assign was_marked   = out_data.was_marked;
    assign hidden_value = out_data.hidden_value;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        buf_full |-> out_valid)
        else $error("skid stage holds a beat while the output register is empty");

    a_pixel_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && mode && !out_valid) |=> out_valid)
        else $error("accepted pixel did not reach the empty output register");

    a_step_write_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        step_write |=> in_stall)
        else $error("input not stalled during the phase recompute");

    a_recompute_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(phase.busy) |-> phase.done)
        else $error("phase recompute ended without a done pulse");
`endif

endmodule
